// ===== src/srtf_pkg.sv =====
package srtf_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic        command;
    logic [7:0]  proc_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] now;
    logic        idle;
    logic [7:0]  running_id;
    logic        segment_start;
    logic        finished;
    logic [15:0] first_run_time;
    logic [15:0] completion_time;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        all_done;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic table_empty;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/srtf_scheduler.sv =====
// Load beat: result registered in COMMIT once the output is free; the next beat is
//   taken back in IDLE. Tick beat: SCAN compares one table entry per cycle over the
//   loaded entries (skipped on an empty table), then COMMIT and IDLE as for a load.
// One beat is in work at a time; a new beat is taken while a result waits.
// Synchronous active-high rst clears counters, time, started/done flags and
//   the output valid flag; the process table and output data are not cleared.
module srtf_scheduler (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srtf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srtf_pkg::out_item_t out_data
);
  import srtf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  srtf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_is_tick (in_data.command == CMD_TICK),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  srtf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/srtf_ctrl.sv =====
module srtf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_is_tick,
  output logic                in_ready,
  input  srtf_pkg::dp_status_t status,
  output srtf_pkg::dp_cmd_t    cmd
);
  import srtf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_is_tick && !status.table_empty) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_COMMIT;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/srtf_dp.sv =====
module srtf_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  srtf_pkg::in_item_t   in_data,
  input  srtf_pkg::dp_cmd_t    cmd,
  output srtf_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output srtf_pkg::out_item_t  out_data
);
  import srtf_pkg::*;

  in_item_t item;

  logic [7:0]  tab_id      [MAX_PROCS];
  logic [15:0] tab_arrival [MAX_PROCS];
  logic [15:0] tab_burst   [MAX_PROCS];
  logic [15:0] tab_rem     [MAX_PROCS];
  logic [15:0] tab_first   [MAX_PROCS];
  logic [MAX_PROCS-1:0] started;
  logic [MAX_PROCS-1:0] done;

  logic [CNT_W-1:0] loaded_count;
  logic [CNT_W-1:0] unfinished_count;
  logic [CNT_W-1:0] unfinished_next;
  logic [15:0]      cur_time;
  logic [7:0]       last_run_id;
  logic             any_run_yet;

  logic [IDX_W-1:0] scan_idx;
  logic             found;
  logic [IDX_W-1:0] best_slot;
  logic [15:0]      best_rem;
  logic [15:0]      best_arr;
  logic [7:0]       best_id;
  logic [15:0]      best_burst;
  logic [15:0]      best_first;
  logic             best_started;

  logic             eligible;
  logic             better;
  logic             table_full;
  logic [IDX_W-1:0] load_slot;
  logic [15:0]      new_rem;
  logic             fin;
  logic [15:0]      ct;
  logic [15:0]      tat;
  out_item_t        out_next;

  assign table_full = (loaded_count == CNT_W'(MAX_PROCS));
  assign load_slot  = loaded_count[IDX_W-1:0];

  assign status.table_empty = (loaded_count == '0);
  assign status.scan_last   = ((CNT_W'(scan_idx) + CNT_W'(1)) == loaded_count);
  assign status.out_free    = !out_valid || out_ready;

  assign eligible = !done[scan_idx] && (tab_arrival[scan_idx] <= cur_time);
  always_comb begin
    better = !found;
    if (tab_rem[scan_idx] != best_rem) begin
      better = better || (tab_rem[scan_idx] < best_rem);
    end else if (tab_arrival[scan_idx] != best_arr) begin
      better = better || (tab_arrival[scan_idx] < best_arr);
    end else begin
      better = better || (tab_id[scan_idx] < best_id);
    end
  end

  assign new_rem = best_rem - 16'd1;
  assign fin     = (new_rem == 16'd0);
  assign ct      = cur_time + 16'd1;
  assign tat     = ct - best_arr;

  always_comb begin
    unfinished_next = unfinished_count;
    out_next = '0;
    out_next.now = cur_time;
    if (item.command == CMD_LOAD) begin
      if (!table_full && (item.burst_time != 16'd0)) begin
        unfinished_next = unfinished_count + CNT_W'(1);
      end
    end else if (found) begin
      out_next.running_id    = best_id;
      out_next.segment_start = !any_run_yet || (last_run_id != best_id);
      if (fin) begin
        if (unfinished_count != '0) begin
          unfinished_next = unfinished_count - CNT_W'(1);
        end
        out_next.finished        = 1'b1;
        out_next.first_run_time  = best_started ? best_first : cur_time;
        out_next.completion_time = ct;
        out_next.turnaround      = tat;
        out_next.waiting         = tat - best_burst;
      end
    end else begin
      out_next.idle = 1'b1;
    end
    out_next.all_done = (unfinished_next == '0);
  end

  // scan state and payload, output data and table writes on commit
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item     <= in_data;
      scan_idx <= '0;
      found    <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (eligible && better) begin
        found        <= 1'b1;
        best_slot    <= scan_idx;
        best_rem     <= tab_rem[scan_idx];
        best_arr     <= tab_arrival[scan_idx];
        best_id      <= tab_id[scan_idx];
        best_burst   <= tab_burst[scan_idx];
        best_first   <= tab_first[scan_idx];
        best_started <= started[scan_idx];
      end
    end
    if (cmd.commit) begin
      out_data <= out_next;
      if (item.command == CMD_LOAD) begin
        if (!table_full) begin
          tab_id[load_slot]      <= item.proc_id;
          tab_arrival[load_slot] <= item.arrival_time;
          tab_burst[load_slot]   <= item.burst_time;
          tab_rem[load_slot]     <= item.burst_time;
        end
      end else if (found) begin
        tab_rem[best_slot] <= new_rem;
        if (!best_started) begin
          tab_first[best_slot] <= cur_time;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started          <= '0;
      done             <= '0;
      loaded_count     <= '0;
      unfinished_count <= '0;
      cur_time         <= '0;
      last_run_id      <= '0;
      any_run_yet      <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (out_valid && out_ready && !cmd.commit) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid        <= 1'b1;
        unfinished_count <= unfinished_next;
        if (item.command == CMD_LOAD) begin
          if (!table_full) begin
            started[load_slot] <= 1'b0;
            done[load_slot]    <= (item.burst_time == 16'd0);
            loaded_count       <= loaded_count + CNT_W'(1);
          end
        end else begin
          cur_time <= ct;
          if (found) begin
            last_run_id         <= best_id;
            any_run_yet         <= 1'b1;
            started[best_slot]  <= 1'b1;
            if (fin) begin
              done[best_slot] <= 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

// ===== src/srtf_checker.sv =====
module srtf_props (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input srtf_pkg::out_item_t out_data
);
  import srtf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous beat in work");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.idle |->
      out_data.running_id == 8'd0 && !out_data.finished && !out_data.segment_start)
    else $error("idle tick carries run fields");

  a_finish_math: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.finished |->
      !out_data.idle && out_data.completion_time == out_data.now + 16'd1)
    else $error("completion time does not follow tick time");

endmodule

bind srtf_scheduler srtf_props u_srtf_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/srtf_checker.sv =====
module srtf_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  srtf_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  srtf_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending,
  output int                  completions
);
  timeunit 1ns;
  timeprecision 1ps;

  import srtf_pkg::*;

  logic [7:0]  slot_pid       [MAX_PROCS];
  logic [15:0] slot_arrival   [MAX_PROCS];
  logic [15:0] slot_burst     [MAX_PROCS];
  logic [15:0] slot_left      [MAX_PROCS];
  logic [15:0] slot_first_run [MAX_PROCS];
  logic        slot_started   [MAX_PROCS];
  logic        slot_done      [MAX_PROCS];
  int          slots_used;
  int          open_procs;
  logic [15:0] sched_time;
  logic [7:0]  prev_pid;
  logic        ran_before;
  out_item_t   expected_outcomes[$];

  function automatic out_item_t srtf_outcome(in_item_t beat);
    out_item_t   res;
    logic        found;
    int          pick;
    logic [15:0] done_at;
    res = '0;
    res.now = sched_time;
    found = 1'b0;
    pick = 0;
    if (beat.command == CMD_LOAD) begin
      if (slots_used < MAX_PROCS) begin
        slot_pid[slots_used]       = beat.proc_id;
        slot_arrival[slots_used]   = beat.arrival_time;
        slot_burst[slots_used]     = beat.burst_time;
        slot_left[slots_used]      = beat.burst_time;
        slot_first_run[slots_used] = 16'd0;
        slot_started[slots_used]   = 1'b0;
        slot_done[slots_used]      = (beat.burst_time == 16'd0);
        if (beat.burst_time != 16'd0) open_procs++;
        slots_used++;
      end
    end else begin
      // least remaining, then earliest arrival, then lowest pid, then lowest slot
      for (int i = 0; i < slots_used; i++) begin
        if (!slot_done[i] && slot_arrival[i] <= sched_time &&
            (!found || slot_left[i] < slot_left[pick] ||
             (slot_left[i] == slot_left[pick] &&
              (slot_arrival[i] < slot_arrival[pick] ||
               (slot_arrival[i] == slot_arrival[pick] &&
                slot_pid[i] < slot_pid[pick]))))) begin
          pick = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        res.idle = 1'b1;
      end else begin
        res.running_id = slot_pid[pick];
        res.segment_start = !ran_before || (prev_pid != slot_pid[pick]);
        prev_pid = slot_pid[pick];
        ran_before = 1'b1;
        if (!slot_started[pick]) begin
          slot_started[pick] = 1'b1;
          slot_first_run[pick] = sched_time;
        end
        slot_left[pick] = slot_left[pick] - 16'd1;
        if (slot_left[pick] == 16'd0) begin
          done_at = sched_time + 16'd1;
          slot_done[pick] = 1'b1;
          if (open_procs > 0) open_procs--;
          res.finished = 1'b1;
          res.first_run_time = slot_first_run[pick];
          res.completion_time = done_at;
          res.turnaround = done_at - slot_arrival[pick];
          res.waiting = res.turnaround - slot_burst[pick];
        end
      end
      sched_time = sched_time + 16'd1;
    end
    res.all_done = (open_procs == 0);
    return res;
  endfunction

  function automatic void check_field(string label, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        slot_started[i] = 1'b0;
        slot_done[i] = 1'b0;
      end
      slots_used = 0;
      open_procs = 0;
      sched_time = 16'd0;
      prev_pid = 8'd0;
      ran_before = 1'b0;
      expected_outcomes.delete();
    end else begin
      if (in_valid && in_ready) expected_outcomes.push_back(srtf_outcome(in_data));
      if (out_valid && out_ready) begin
        if (expected_outcomes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected beat, expected none, actual %p", $time, out_data);
        end else begin
          want = expected_outcomes.pop_front();
          check_field("now", want.now, out_data.now);
          check_field("idle", 16'(want.idle), 16'(out_data.idle));
          check_field("running_id", 16'(want.running_id), 16'(out_data.running_id));
          check_field("segment_start", 16'(want.segment_start),
                      16'(out_data.segment_start));
          check_field("finished", 16'(want.finished), 16'(out_data.finished));
          check_field("first_run_time", want.first_run_time, out_data.first_run_time);
          check_field("completion_time", want.completion_time, out_data.completion_time);
          check_field("turnaround", want.turnaround, out_data.turnaround);
          check_field("waiting", want.waiting, out_data.waiting);
          check_field("all_done", 16'(want.all_done), 16'(out_data.all_done));
          if (want.finished) completions++;
        end
      end
    end
    pending = expected_outcomes.size();
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srtf_pkg::*;

  localparam int RANDOM_ITEMS = 1580;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 5000000;

  typedef enum {ALWAYS_READY, COIN_TOSS, MOSTLY_STALLED, DUTY_CYCLE} stall_mode_e;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int          fail_count;
  int          pending;
  int          completions;
  logic        in_fire = 1'b0;
  int          cycle_count = 0;
  logic [15:0] tick_clock = 16'd0;
  int          loads_sent = 0;
  int          ticks_sent = 0;
  int          hold_requests = 0;

  always #10 clk = ~clk;

  srtf_scheduler DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  srtf_checker sched_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .completions(completions)
  );

  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    cycle_count <= cycle_count + 1;
  end

  task automatic send_beat(input in_item_t beat);
    in_data  <= beat;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_fire);
    if (beat.command == CMD_TICK) begin
      ticks_sent++;
      tick_clock++;
    end else begin
      loads_sent++;
    end
  endtask

  task automatic load_proc(input logic [7:0] pid, input logic [15:0] arr,
                           input logic [15:0] bst);
    in_item_t beat;
    beat.command      = CMD_LOAD;
    beat.proc_id      = pid;
    beat.arrival_time = arr;
    beat.burst_time   = bst;
    send_beat(beat);
  endtask

  task automatic tick_once();
    in_item_t beat;
    beat.command      = CMD_TICK;
    beat.proc_id      = 8'($urandom);
    beat.arrival_time = 16'($urandom);
    beat.burst_time   = 16'($urandom);
    send_beat(beat);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  initial begin
    int          holds_done;
    stall_mode_e mode;
    int          mode_left;
    int          phase;
    holds_done = 0;
    mode = ALWAYS_READY;
    mode_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (holds_done < hold_requests) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        phase++;
        case (mode)
          ALWAYS_READY:   out_ready <= 1'b1;
          COIN_TOSS:      out_ready <= 1'($urandom_range(0, 1));
          MOSTLY_STALLED: out_ready <= ($urandom_range(0, 3) == 0);
          default:        out_ready <= ((phase % 7) < 4);
        endcase
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d beats still expected", cycle_count, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int          burst_left;
    logic        do_load;
    logic [7:0]  pid;
    logic [15:0] arr;
    logic [15:0] bst;
    logic [15:0] last_arrival;
    burst_left = 0;
    last_arrival = 16'd0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tick_once();
    load_proc(8'h00, 16'd0, 16'd0);
    tick_once();
    load_proc(8'h11, 16'd2, 16'd3);
    load_proc(8'h22, 16'd3, 16'd1);
    tick_once();
    tick_once();
    load_proc(8'h05, 16'd4, 16'd2);
    tick_once();
    tick_once();
    load_proc(8'h04, 16'd4, 16'd2);
    load_proc(8'h04, 16'd4, 16'd2);
    repeat (7) tick_once();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      end
      burst_left--;
      if (n == 500 || n == 1100) hold_requests++;
      do_load = (loads_sent < MAX_PROCS) ? ($urandom_range(0, 5) == 0)
                                         : ($urandom_range(0, 19) == 0);
      if (do_load) begin
        pid = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
          0, 1, 2: arr = tick_clock;
          3, 4:    arr = tick_clock + 16'($urandom_range(1, 20));
          5, 6:    arr = tick_clock - 16'($urandom_range(0, (tick_clock < 10) ? tick_clock : 10));
          7:       arr = 16'($urandom);
          default: arr = last_arrival;
        endcase
        bst = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(9, 60))
                                          : 16'($urandom_range(1, 8));
        last_arrival = arr;
        load_proc(pid, arr, bst);
      end else begin
        tick_once();
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Run covered %0d loads (%0d into a full table) and %0d ticks under bursts and stalls,",
             loads_sent, (loads_sent > MAX_PROCS) ? loads_sent - MAX_PROCS : 0, ticks_sent);
    $display("with %0d completions checked and %0d field mismatches.", completions, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/srtf_pkg.sv
src/srtf_ctrl.sv
src/srtf_dp.sv
src/srtf_scheduler.sv
src/srtf_checker.sv
tb/srtf_checker.sv
tb/tb_top.sv
